### hdl/pb_pkg.sv
// Shared types, widths and constants of the pointer ballistics block.
`default_nettype none
package pb_pkg;

    localparam int REG_W     = 11;
    localparam int MOVE_W    = 9;
    localparam int FRAC_W    = 16;
    localparam int ACCEL_W   = 10;
    localparam int INTEN_W   = 10;
    localparam int GAIN_W    = REG_W + ACCEL_W;
    localparam int SHIFT_W   = 21;
    localparam int APPLIED_W = 16;
    localparam int QUO_W     = 13;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS      = 3'd0,
        CFG_SCREEN_W  = 3'd1,
        CFG_SCREEN_H  = 3'd2,
        CFG_CURSOR_W  = 3'd3,
        CFG_CURSOR_H  = 3'd4
    } t_cfg_idx;

    localparam logic [REG_W-1:0] RST_SENS     = 11'd563;
    localparam logic [REG_W-1:0] RST_SCREEN_W = 11'd800;
    localparam logic [REG_W-1:0] RST_SCREEN_H = 11'd600;
    localparam logic [REG_W-1:0] RST_CURSOR_W = 11'd16;
    localparam logic [REG_W-1:0] RST_CURSOR_H = 11'd16;

    localparam logic [INTEN_W-1:0] INTEN_FAST = 10'd12;
    localparam logic [INTEN_W-1:0] INTEN_HIGH = 10'd8;
    localparam logic [INTEN_W-1:0] INTEN_MID  = 10'd4;
    localparam logic [INTEN_W-1:0] INTEN_LOW  = 10'd2;

    localparam logic [ACCEL_W-1:0] ACCEL_FAST = 10'd563;
    localparam logic [ACCEL_W-1:0] ACCEL_HIGH = 10'd461;
    localparam logic [ACCEL_W-1:0] ACCEL_MID  = 10'd384;
    localparam logic [ACCEL_W-1:0] ACCEL_LOW  = 10'd307;
    localparam logic [ACCEL_W-1:0] ACCEL_UNIT = 10'd256;

    typedef struct packed {
        logic                        done;
        logic signed [APPLIED_W-1:0] applied;
    } t_lane_res;

    function automatic logic [ACCEL_W-1:0] accel_of(input logic [INTEN_W-1:0] inten);
        logic [ACCEL_W-1:0] a;
        priority if (inten > INTEN_FAST) a = ACCEL_FAST;
        else if (inten > INTEN_HIGH)     a = ACCEL_HIGH;
        else if (inten > INTEN_MID)      a = ACCEL_MID;
        else if (inten > INTEN_LOW)      a = ACCEL_LOW;
        else                             a = ACCEL_UNIT;
        return a;
    endfunction

endpackage
`default_nettype wire

### hdl/pb_if.sv
// Channel interfaces: movement words in, cursor words out, register writes.
`default_nettype none
interface pb_move_if import pb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    modport source (output valid, output move_x, output move_y, input ready);
    modport sink   (input valid, input move_x, input move_y, output ready);
endinterface

interface pb_cursor_if import pb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REG_W-1:0] cursor_x;
    logic [REG_W-1:0] cursor_y;
    modport source (output valid, output cursor_x, output cursor_y, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, output ready);
endinterface

interface pb_cfg_if import pb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/pb_lane.sv
// One axis lane: remainder accumulate, gain multiply, serial remainder divide.
`default_nettype none
module pb_lane
    import pb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [MOVE_W-1:0] i_d,
    input  wire logic [GAIN_W-1:0]        i_gain,
    output t_lane_res                     o_res
);

    localparam int PROD_W = FRAC_W + GAIN_W + 1;
    localparam int CNT_W  = $clog2(QUO_W);

    typedef enum logic [3:0] {
        L_IDLE  = 4'b0001,
        L_MUL   = 4'b0010,
        L_SPLIT = 4'b0100,
        L_DIV   = 4'b1000
    } t_lane_state;

    t_lane_state                 r_state, n_state;
    logic signed [FRAC_W-1:0]    r_frac, n_frac;
    logic signed [FRAC_W-1:0]    r_acc, n_acc;
    logic signed [PROD_W-1:0]    r_prod, n_prod;
    logic                        r_neg, n_neg;
    logic [GAIN_W-1:0]           r_part, n_part;
    logic [QUO_W-1:0]            r_dvd, n_dvd;
    logic [QUO_W-1:0]            r_quo, n_quo;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    t_lane_res                   r_res, n_res;

    logic signed [MOVE_W+4:0]    w_d32;
    logic signed [FRAC_W:0]      w_sum;
    logic signed [FRAC_W-1:0]    w_sat;
    logic signed [GAIN_W:0]      w_gain_s;
    logic [PROD_W-1:0]           w_mag;
    logic [APPLIED_W-1:0]        w_app_mag;
    logic [GAIN_W:0]             w_trial;
    logic [GAIN_W:0]             w_diff;
    logic                        w_ge;
    logic [QUO_W-1:0]            w_quo;

    assign w_d32    = {i_d, 5'b0};
    assign w_sum    = (FRAC_W+1)'(r_frac) + (FRAC_W+1)'(w_d32);
    assign w_sat    = (w_sum[FRAC_W] != w_sum[FRAC_W-1])
                    ? {w_sum[FRAC_W], {(FRAC_W-1){~w_sum[FRAC_W]}}}
                    : w_sum[FRAC_W-1:0];
    assign w_gain_s = {1'b0, i_gain};
    assign w_mag    = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign w_app_mag = w_mag[SHIFT_W+APPLIED_W-1:SHIFT_W];
    assign w_trial  = {r_part, r_dvd[QUO_W-1]};
    assign w_diff   = w_trial - {1'b0, i_gain};
    assign w_ge     = (w_trial >= {1'b0, i_gain});
    assign w_quo    = {r_quo[QUO_W-2:0], w_ge};

    always_comb begin
        n_state = r_state;
        n_frac  = r_frac;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_neg   = r_neg;
        n_part  = r_part;
        n_dvd   = r_dvd;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_res.done = 1'b0;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_acc   = w_sat;
                    n_state = L_MUL;
                end
            end
            L_MUL: begin
                n_prod  = r_acc * w_gain_s;
                n_state = L_SPLIT;
            end
            L_SPLIT: begin
                if (i_gain == '0) begin
                    n_frac      = r_acc;
                    n_res.done  = 1'b1;
                    n_res.applied = '0;
                    n_state     = L_IDLE;
                end else begin
                    n_neg  = r_prod[PROD_W-1];
                    n_res.applied = r_prod[PROD_W-1] ? APPLIED_W'(-w_app_mag)
                                                     : APPLIED_W'(w_app_mag);
                    n_part = GAIN_W'(w_mag[SHIFT_W-1:QUO_W]);
                    n_dvd  = w_mag[QUO_W-1:0];
                    n_quo  = '0;
                    n_cnt  = '0;
                    n_state = L_DIV;
                end
            end
            L_DIV: begin
                n_part = w_ge ? w_diff[GAIN_W-1:0] : w_trial[GAIN_W-1:0];
                n_dvd  = {r_dvd[QUO_W-2:0], 1'b0};
                n_quo  = w_quo;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W-1)) begin
                    n_frac     = r_neg ? -FRAC_W'(w_quo) : FRAC_W'(w_quo);
                    n_res.done = 1'b1;
                    n_state    = L_IDLE;
                end
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= L_IDLE;
            r_frac     <= '0;
            r_res.done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_frac     <= n_frac;
            r_res.done <= n_res.done;
        end
        r_res.applied <= n_res.applied;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_part <= n_part;
        r_dvd  <= n_dvd;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
    end

    assign o_res = r_res;

    a_part_below_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_DIV) |-> (r_part < i_gain))
        else $error("partial remainder not below divisor");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_DIV) |-> (r_cnt <= CNT_W'(QUO_W-1)))
        else $error("divide ran past its last step");

endmodule
`default_nettype wire

### hdl/pb_merge.sv
// Merges the two lane moves into the cursor position and clamps it to the screen.
`default_nettype none
module pb_merge
    import pb_pkg::*;
#(
    parameter int COORD_BITS = 11
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_lane_res             i_res_x,
    input  wire t_lane_res             i_res_y,
    input  wire logic [REG_W-1:0]      i_screen_w,
    input  wire logic [REG_W-1:0]      i_screen_h,
    input  wire logic [REG_W-1:0]      i_cursor_w,
    input  wire logic [REG_W-1:0]      i_cursor_h,
    output logic [COORD_BITS-1:0]      o_pos_x,
    output logic [COORD_BITS-1:0]      o_pos_y
);

    localparam int SUM_W = COORD_BITS + APPLIED_W + 1;

    logic [COORD_BITS-1:0]   r_pos_x, n_pos_x;
    logic [COORD_BITS-1:0]   r_pos_y, n_pos_y;
    logic [REG_W:0]          w_dif_x, w_dif_y;
    logic [REG_W-1:0]        w_lim_x, w_lim_y;
    logic signed [SUM_W-1:0] w_sum_x, w_sum_y;
    logic signed [SUM_W-1:0] w_clp_x, w_clp_y;

    assign w_dif_x = {1'b0, i_screen_w} - {1'b0, i_cursor_w};
    assign w_dif_y = {1'b0, i_screen_h} - {1'b0, i_cursor_h};
    assign w_lim_x = w_dif_x[REG_W] ? '0 : w_dif_x[REG_W-1:0];
    assign w_lim_y = w_dif_y[REG_W] ? '0 : w_dif_y[REG_W-1:0];

    // x moves with the mouse, y against it (mouse up is screen up)
    assign w_sum_x = $signed(SUM_W'(r_pos_x)) + SUM_W'(i_res_x.applied);
    assign w_sum_y = $signed(SUM_W'(r_pos_y)) - SUM_W'(i_res_y.applied);

    always_comb begin
        priority if (w_sum_x < 0)                          w_clp_x = '0;
        else if (w_sum_x > $signed(SUM_W'(w_lim_x)))       w_clp_x = SUM_W'(w_lim_x);
        else                                               w_clp_x = w_sum_x;
        priority if (w_sum_y < 0)                          w_clp_y = '0;
        else if (w_sum_y > $signed(SUM_W'(w_lim_y)))       w_clp_y = SUM_W'(w_lim_y);
        else                                               w_clp_y = w_sum_y;
        n_pos_x = i_res_x.done ? w_clp_x[COORD_BITS-1:0] : r_pos_x;
        n_pos_y = i_res_y.done ? w_clp_y[COORD_BITS-1:0] : r_pos_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= COORD_BITS'(400);
            r_pos_y <= COORD_BITS'(300);
        end else begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
        end
    end

    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;

endmodule
`default_nettype wire

### hdl/pointer_ballistics.sv
// Top level of the pointer ballistics block: mouse moves in, cursor position out.
//
// i_move carries one mouse movement word (move_x, move_y, signed counts, up
// positive). o_cursor returns one word per movement with the clamped cursor
// position (cursor_x, cursor_y, down positive). i_cfg writes the five
// registers: sensitivity, screen width and height, cursor width and height;
// it is always ready and is meant to be written while the block is idle.
// A nonzero movement takes these steps after acceptance: intensity at
// acceptance, gain and the remainder update, the multiply, the split, the
// bit-serial remainder divider in each axis lane (both lanes run in lockstep),
// the merge/clamp and the load of the output register. A zero movement
// returns the held position. One movement is in flight at a time; the next
// word is accepted once the result loads into the output register, even if
// the receiver has not taken the result.
// When the receiver stalls, the result waits in the output register and the
// next result waits in the merge stage until the register frees.
// Reset puts the cursor at (400, 300), clears both remainders and loads the
// default registers.
`default_nettype none
module pointer_ballistics
    import pb_pkg::*;
#(
    parameter int COORD_BITS = 11
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pb_move_if.sink      i_move,
    pb_cfg_if.sink       i_cfg,
    pb_cursor_if.source  o_cursor
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_POST = 3'b100
    } t_top_state;

    t_top_state            r_state, n_state;
    logic [REG_W-1:0]      r_sens, r_scr_w, r_scr_h, r_cur_w, r_cur_h;
    logic [ACCEL_W-1:0]    r_accel;
    logic [GAIN_W-1:0]     r_gain;
    logic signed [MOVE_W-1:0] r_dx, r_dy;
    logic                  r_start;
    logic                  r_out_valid;
    logic [REG_W-1:0]      r_out_x, r_out_y;

    logic                     w_accept;
    logic                     w_zero;
    logic signed [MOVE_W:0]   w_sx, w_sy;
    logic [MOVE_W-1:0]        w_ax, w_ay, w_max, w_min;
    logic [INTEN_W-1:0]       w_inten;
    logic [ACCEL_W-1:0]       w_accel;
    logic                     w_load;
    t_lane_res                w_res_x, w_res_y;
    logic [COORD_BITS-1:0]    w_pos_x, w_pos_y;

    assign i_move.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_accept     = i_move.valid && i_move.ready;
    assign w_zero       = (i_move.move_x == '0) && (i_move.move_y == '0);

    assign w_sx    = (MOVE_W+1)'(i_move.move_x);
    assign w_sy    = (MOVE_W+1)'(i_move.move_y);
    assign w_ax    = w_sx[MOVE_W] ? MOVE_W'(-w_sx) : MOVE_W'(w_sx);
    assign w_ay    = w_sy[MOVE_W] ? MOVE_W'(-w_sy) : MOVE_W'(w_sy);
    assign w_max   = (w_ax > w_ay) ? w_ax : w_ay;
    assign w_min   = (w_ax > w_ay) ? w_ay : w_ax;
    assign w_inten = INTEN_W'(w_max) + INTEN_W'(w_min >> 1);
    assign w_accel = accel_of(w_inten);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens  <= RST_SENS;
            r_scr_w <= RST_SCREEN_W;
            r_scr_h <= RST_SCREEN_H;
            r_cur_w <= RST_CURSOR_W;
            r_cur_h <= RST_CURSOR_H;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SENS:     r_sens  <= i_cfg.data;
                CFG_SCREEN_W: r_scr_w <= i_cfg.data;
                CFG_SCREEN_H: r_scr_h <= i_cfg.data;
                CFG_CURSOR_W: r_cur_w <= i_cfg.data;
                CFG_CURSOR_H: r_cur_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_accel <= w_accel;
            r_dx    <= i_move.move_x;
            r_dy    <= i_move.move_y;
        end
        // gain lands while the lanes update the remainder
        if (r_start) begin
            r_gain <= GAIN_W'(r_sens) * GAIN_W'(r_accel);
        end
    end

    pb_lane u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_d     (r_dx),
        .i_gain  (r_gain),
        .o_res   (w_res_x)
    );

    pb_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_d     (r_dy),
        .i_gain  (r_gain),
        .o_res   (w_res_y)
    );

    pb_merge #(.COORD_BITS(COORD_BITS)) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_x    (w_res_x),
        .i_res_y    (w_res_y),
        .i_screen_w (r_scr_w),
        .i_screen_h (r_scr_h),
        .i_cursor_w (r_cur_w),
        .i_cursor_h (r_cur_h),
        .o_pos_x    (w_pos_x),
        .o_pos_y    (w_pos_y)
    );

    assign w_load = (r_state == S_POST) && (!r_out_valid || o_cursor.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = w_zero ? S_POST : S_RUN;
            S_RUN:  if (w_res_x.done) n_state = S_POST;
            S_POST: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept && !w_zero;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_cursor.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_out_x <= REG_W'(w_pos_x);
            r_out_y <= REG_W'(w_pos_y);
        end
    end

    assign o_cursor.valid    = r_out_valid;
    assign o_cursor.cursor_x = r_out_x;
    assign o_cursor.cursor_y = r_out_y;

    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_x.done == w_res_y.done)
        else $error("axis lanes out of step");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_x.done |-> (r_state == S_RUN))
        else $error("lane finished outside a run");

    a_zero_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_zero) |=> (r_state == S_POST) && !r_start)
        else $error("zero movement started the lanes");

endmodule
`default_nettype wire
